// ----- hdl/status_synced_adc_frame_deframer_top_macros.svh -----
// Assertion macros shared by the deframer checker.
`ifndef STATUS_SYNCED_ADC_FRAME_DEFRAMER_TOP_MACROS_SVH
`define STATUS_SYNCED_ADC_FRAME_DEFRAMER_TOP_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define SSFD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the following cycle.
`define SSFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/ssfd_pkg.sv -----
// Types, constants and codes shared by the status-synced frame deframer.
package ssfd_pkg;

	localparam int CHANNELS_PER_SIDE = 8;
	localparam int NUM_SAMPLES = 2 * CHANNELS_PER_SIDE;
	localparam int IDX_W = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;
	localparam int WIF_W = $clog2(2 * CHANNELS_PER_SIDE + 2);

	localparam int WORD_W = 24;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_LEFT_STATUS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_STATUS = CFG_IDX_W'(1);

	localparam logic [WORD_W-1:0] LEFT_STATUS_RESET = 24'hC00000;
	localparam logic [WORD_W-1:0] RIGHT_STATUS_RESET = 24'hC0000F;

	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_MISMATCH = 2'd1,
		KIND_READFAIL = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_CLEAR,
		ACC_LOAD,
		ACC_SHIFT
	} acc_op_t;

	typedef enum logic [1:0] {
		ST_HUNT,
		ST_FRAME,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic read_failed;
	} in_beat_t;

	typedef struct packed {
		kind_t kind;
		logic [3:0] channel;
		logic signed [WORD_W-1:0] sample;
		logic [WORD_W-1:0] bad_word;
		logic last;
	} out_beat_t;

	typedef struct packed {
		acc_op_t acc_op;
		logic buf_we;
		logic [IDX_W-1:0] buf_addr;
		logic out_load;
		kind_t out_kind;
		logic out_last;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic top_byte_hit;
		logic left_hit;
		logic right_hit;
	} status_t;

endpackage

// ----- hdl/ssfd_ctrl.sv -----
// Controller: hunt, frame tracking and sample burst sequencing.
module ssfd_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic read_failed,
	input ssfd_pkg::status_t sts,
	output ssfd_pkg::cmd_t cmd
);
	import ssfd_pkg::*;

	localparam logic [WIF_W-1:0] WIF_RIGHT = WIF_W'(CHANNELS_PER_SIDE);
	localparam logic [WIF_W-1:0] WIF_LAST_CH = WIF_W'(2 * CHANNELS_PER_SIDE);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_SAMPLES - 1);

	state_t state_q, state_d;
	logic [1:0] sync_cnt_q, sync_cnt_d;
	logic [1:0] byte_cnt_q, byte_cnt_d;
	logic [WIF_W-1:0] wif_q, wif_d;
	logic [IDX_W-1:0] emit_idx_q, emit_idx_d;
	logic accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			sync_cnt_q <= '0;
			byte_cnt_q <= '0;
			wif_q <= '0;
			emit_idx_q <= '0;
		end else begin
			state_q <= state_d;
			sync_cnt_q <= sync_cnt_d;
			byte_cnt_q <= byte_cnt_d;
			wif_q <= wif_d;
			emit_idx_q <= emit_idx_d;
		end
	end

	assign in_ready = (state_q != ST_EMIT) && sts.out_free;
	assign accept = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		sync_cnt_d = sync_cnt_q;
		byte_cnt_d = byte_cnt_q;
		wif_d = wif_q;
		emit_idx_d = emit_idx_q;
		cmd = '{acc_op: ACC_HOLD, buf_we: 1'b0, buf_addr: '0, out_load: 1'b0,
			out_kind: KIND_SAMPLE, out_last: 1'b0};

		case (state_q)
			ST_HUNT: begin
				if (accept && read_failed) begin
					sync_cnt_d = '0;
					cmd.acc_op = ACC_CLEAR;
					cmd.out_load = 1'b1;
					cmd.out_kind = KIND_READFAIL;
					cmd.out_last = 1'b1;
				end else if (accept) begin
					case (sync_cnt_q)
						2'd0: begin
							if (sts.top_byte_hit) begin
								cmd.acc_op = ACC_LOAD;
								sync_cnt_d = 2'd1;
							end
						end
						2'd1: begin
							cmd.acc_op = ACC_SHIFT;
							sync_cnt_d = 2'd2;
						end
						default: begin
							cmd.acc_op = ACC_CLEAR;
							sync_cnt_d = '0;
							if (sts.left_hit) begin
								state_d = ST_FRAME;
								byte_cnt_d = '0;
								wif_d = '0;
							end
						end
					endcase
				end
			end
			ST_FRAME: begin
				if (accept && read_failed) begin
					state_d = ST_HUNT;
					sync_cnt_d = '0;
					byte_cnt_d = '0;
					wif_d = '0;
					cmd.acc_op = ACC_CLEAR;
					cmd.out_load = 1'b1;
					cmd.out_kind = KIND_READFAIL;
					cmd.out_last = 1'b1;
				end else if (accept && byte_cnt_q != 2'd2) begin
					cmd.acc_op = ACC_SHIFT;
					byte_cnt_d = byte_cnt_q + 2'd1;
				end else if (accept) begin
					// The third byte completes a word.
					cmd.acc_op = ACC_CLEAR;
					byte_cnt_d = '0;
					if (wif_q < WIF_RIGHT) begin
						cmd.buf_we = 1'b1;
						cmd.buf_addr = IDX_W'(wif_q);
						wif_d = wif_q + WIF_W'(1);
					end else if (wif_q == WIF_RIGHT) begin
						if (sts.right_hit) begin
							wif_d = wif_q + WIF_W'(1);
						end else begin
							state_d = ST_HUNT;
							wif_d = '0;
							cmd.out_load = 1'b1;
							cmd.out_kind = KIND_MISMATCH;
							cmd.out_last = 1'b1;
						end
					end else if (wif_q <= WIF_LAST_CH) begin
						cmd.buf_we = 1'b1;
						cmd.buf_addr = IDX_W'(wif_q - WIF_W'(1));
						wif_d = wif_q + WIF_W'(1);
					end else begin
						wif_d = '0;
						if (sts.left_hit) begin
							state_d = ST_EMIT;
							emit_idx_d = '0;
						end else begin
							state_d = ST_HUNT;
							cmd.out_load = 1'b1;
							cmd.out_kind = KIND_MISMATCH;
							cmd.out_last = 1'b1;
						end
					end
				end
			end
			ST_EMIT: begin
				cmd.buf_addr = emit_idx_q;
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = KIND_SAMPLE;
					cmd.out_last = (emit_idx_q == IDX_LAST);
					emit_idx_d = emit_idx_q + IDX_W'(1);
					if (emit_idx_q == IDX_LAST) begin
						state_d = ST_FRAME;
						emit_idx_d = '0;
					end
				end
			end
			default: begin
				state_d = ST_HUNT;
			end
		endcase
	end

endmodule

// ----- hdl/ssfd_dp.sv -----
// Datapath: status registers, word packer, sample buffer and output register.
module ssfd_dp (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [ssfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ssfd_pkg::WORD_W-1:0] cfg_data,
	input logic [7:0] rx_byte,
	input logic out_ready,
	input ssfd_pkg::cmd_t cmd,
	output ssfd_pkg::status_t sts,
	output logic out_valid,
	output ssfd_pkg::out_beat_t out_data
);
	import ssfd_pkg::*;

	logic [WORD_W-1:0] left_q, right_q, acc_q;
	logic [WORD_W-1:0] word_next;
	logic [WORD_W-1:0] buf_q [NUM_SAMPLES];
	logic out_valid_q;
	out_beat_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= LEFT_STATUS_RESET;
			right_q <= RIGHT_STATUS_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_LEFT_STATUS) begin
				left_q <= cfg_data;
			end else if (cfg_index == REG_RIGHT_STATUS) begin
				right_q <= cfg_data;
			end
		end
	end

	assign word_next = {acc_q[WORD_W-9:0], rx_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else begin
			case (cmd.acc_op)
				ACC_CLEAR: acc_q <= '0;
				ACC_LOAD: acc_q <= WORD_W'(rx_byte);
				ACC_SHIFT: acc_q <= word_next;
				default: acc_q <= acc_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.buf_we) begin
			buf_q[cmd.buf_addr] <= word_next;
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.top_byte_hit = (rx_byte == left_q[WORD_W-1:WORD_W-8]);
	assign sts.left_hit = (word_next == left_q);
	assign sts.right_hit = (word_next == right_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.kind <= cmd.out_kind;
			out_q.last <= cmd.out_last;
			case (cmd.out_kind)
				KIND_SAMPLE: begin
					out_q.channel <= 4'(cmd.buf_addr);
					out_q.sample <= $signed(buf_q[cmd.buf_addr]);
					out_q.bad_word <= '0;
				end
				KIND_MISMATCH: begin
					out_q.channel <= '0;
					out_q.sample <= '0;
					out_q.bad_word <= word_next;
				end
				default: begin
					out_q.channel <= '0;
					out_q.sample <= '0;
					out_q.bad_word <= '0;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

// ----- hdl/status_synced_adc_frame_deframer_top.sv -----
// Top level of the status-word synchronized converter frame deframer.
//
//   Channel   Direction  Handshake           Beat contents
//   in        in         in_valid/in_ready   rx_byte, read_failed
//   out       out        out_valid/out_ready kind, channel, sample, bad_word, last
//   cfg       in         cfg_we              cfg_index, cfg_data (status words)
//
// One byte beat is taken per cycle while hunting and framing; the controller steps
// through hunt, word packing and frame position once per byte.
// A matching closing status word starts a burst of 2 * CHANNELS_PER_SIDE sample beats,
// one per cycle from the sample buffer while the output register is free, and no byte is taken during the burst.
// A byte is taken only when the output register is empty or drains that cycle.
// Reset clears the parse state and loads the default status words, not the buffer.
module status_synced_adc_frame_deframer_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input ssfd_pkg::in_beat_t in_data,
	output logic out_valid,
	input logic out_ready,
	output ssfd_pkg::out_beat_t out_data,
	input logic cfg_we,
	input logic [ssfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ssfd_pkg::WORD_W-1:0] cfg_data
);
	import ssfd_pkg::*;

	// Commands from the controller and status back from the datapath.
	cmd_t cmd;
	status_t sts;

	ssfd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.read_failed(in_data.read_failed),
		.sts(sts),
		.cmd(cmd)
	);

	// The datapath compares the word formed with the current byte, so status
	// words are checked in the same cycle their last byte arrives.
	ssfd_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.rx_byte(in_data.rx_byte),
		.out_ready(out_ready),
		.cmd(cmd),
		.sts(sts),
		.out_valid(out_valid),
		.out_data(out_data)
	);

endmodule

// ----- hdl/ssfd_chk.sv -----
// Port-level checker for the deframer, bound to the top level.
`include "status_synced_adc_frame_deframer_top_macros.svh"

module ssfd_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input ssfd_pkg::in_beat_t in_data,
	input logic out_valid,
	input logic out_ready,
	input ssfd_pkg::out_beat_t out_data
);
	import ssfd_pkg::*;

	`SSFD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "output beat changed while stalled")

	`SSFD_ASSERT_NEXT(a_readfail_result, clk, arst_n, in_valid && in_ready && in_data.read_failed, out_valid && out_data.kind == KIND_READFAIL && out_data.last, "failed read did not give an error beat")

	`SSFD_ASSERT_SAME(a_burst_blocks_input, clk, arst_n, out_valid && out_data.kind == KIND_SAMPLE && !out_data.last, !in_ready, "byte taken during a sample burst")

	`SSFD_ASSERT_NEXT(a_burst_order, clk, arst_n, out_valid && out_ready && out_data.kind == KIND_SAMPLE && !out_data.last, out_valid && out_data.kind == KIND_SAMPLE && out_data.channel == 4'($past(out_data.channel) + 4'd1), "sample burst out of channel order")

endmodule

bind status_synced_adc_frame_deframer_top ssfd_chk u_ssfd_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.in_data(in_data),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data(out_data)
);
